[hdl/sbit_pkg.sv]
`timescale 1ns / 1ps
package sbit_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] point_x;
        logic [31:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic [6:0]  entry_count;
    } out_item_t;

endpackage

[hdl/sorted_breakpoint_interpolation_table_unit.sv]
`timescale 1ns / 1ps
// Append, full and empty results are posted straight from idle. A sorted insert
// shifts entries one by one; a lookup checks the range, then binary-searches, and
// interpolates with a multiply and a divide on a miss (at most 7 probes at depth 64).
// Throughput: one request at a time; the next can enter the engine the cycle after
// the previous result is taken. The first sorted insert after appends re-sorts.
// Reset: count cleared, sort_on_insert set; table contents undefined.
module sorted_breakpoint_interpolation_table_unit
    import sbit_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic     sort_reg;
    logic     q_valid, q_take;
    in_item_t q_data;

    // hold the ordering mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sort_reg <= 1'b1;
        else if (cfg_we)
            sort_reg <= cfg_wdata;
    end

    // front: buffer requests so the source need not wait for the engine until the queue is full
    sbit_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_stall (in_stall),
        .wr_data  (in_data),
        .rd_valid (q_valid),
        .rd_take  (q_take),
        .rd_data  (q_data)
    );

    // back: table, sorting, search and interpolation
    sbit_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .sort_on_insert (sort_reg),
        .req_valid      (q_valid),
        .req_take       (q_take),
        .req_data       (q_data),
        .res_valid      (out_valid),
        .res_stall      (out_stall),
        .res_data       (out_data)
    );

endmodule

[hdl/sbit_queue.sv]
`timescale 1ns / 1ps
module sbit_queue
    import sbit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_stall,
    input  in_item_t wr_data,
    output logic     rd_valid,
    input  logic     rd_take,
    output in_item_t rd_data
);

    // two-entry queue between the front and the back
    in_item_t   slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] fill_reg;

    assign wr_stall = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && !wr_stall)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && !wr_stall)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_take)
            begin
                rptr_reg <= ~rptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, wr_valid && !wr_stall} - {1'b0, rd_take};
        end
    end

    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_take |-> rd_valid) else $error("queue read while empty");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3) else $error("queue fill overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd2) |-> wr_stall) else $error("queue full without stall");

endmodule

[hdl/sbit_engine.sv]
`timescale 1ns / 1ps
module sbit_engine
    import sbit_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sort_on_insert,
    input  logic      req_valid,
    output logic      req_take,
    input  in_item_t  req_data,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = AW + 2; // signed search bounds, -1 .. depth

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_SHIFT  = 13'b0000000000010,
        S_SHWR   = 13'b0000000000100,
        S_RDLO   = 13'b0000000001000,
        S_RDHI   = 13'b0000000010000,
        S_CHK    = 13'b0000000100000,
        S_PROBE  = 13'b0000001000000,
        S_CMP    = 13'b0000010000000,
        S_RDA    = 13'b0000100000000,
        S_RDB    = 13'b0001000000000,
        S_MUL    = 13'b0010000000000,
        S_DIV    = 13'b0100000000000,
        S_KEY    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] xmem [TABLE_DEPTH];
    logic [31:0] ymem [TABLE_DEPTH];

    logic [CW-1:0] count_reg;
    logic          ordered_reg;
    in_item_t      item_reg;
    logic [AW-1:0] raddr;
    logic [31:0]   xr_reg, yr_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wx, wy;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] idx_reg;
    logic [31:0]   key_x_reg, key_y_reg;
    logic signed [SW-1:0] l_reg, r_reg;
    logic [31:0]   first_x_reg;
    logic signed [32:0] ax_reg, ay_reg, dy_reg;
    logic [32:0]   dx_reg, dq_reg;
    logic [65:0]   num_reg;
    logic [32:0]   rem_reg;
    logic [6:0]    bit_reg;
    logic          neg_reg;
    logic          out_full_reg;
    out_item_t     out_reg;

    logic signed [SW-1:0] mid;
    logic [33:0]   trial;
    logic [CW:0]   cnt_ext;
    logic          place_now;
    logic          sort_done;
    logic [31:0]   mag;
    logic [63:0]   prod;

    assign mid      = (l_reg + r_reg) >>> 1;
    assign cnt_ext  = {1'b0, count_reg};
    assign trial    = {rem_reg, num_reg[65]} - {1'b0, dx_reg};
    // drop the key in at pos once the entry below is not larger, or at the bottom
    assign place_now = (pos_reg == '0) || ($signed(xr_reg) <= $signed(key_x_reg));
    assign sort_done = ((CW+1)'(idx_reg) + (CW+1)'(1)) >= cnt_ext;
    assign mag      = dy_reg[32] ? 32'(-dy_reg) : dy_reg[31:0];
    assign prod     = mag * dq_reg[31:0];
    assign res_valid = out_full_reg;
    assign res_data  = out_reg;
    assign req_take  = (state_reg == S_IDLE) && req_valid && !out_full_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            xmem[waddr] <= wx;
            ymem[waddr] <= wy;
        end
        xr_reg <= xmem[raddr];
        yr_reg <= ymem[raddr];
    end

    // memory control
    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg;
        wx    = xr_reg;
        wy    = yr_reg;
        raddr = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                raddr = AW'(count_reg - 1'b1);
                if (req_take && req_data.req_type == REQ_INSERT
                    && cnt_ext < (CW+1)'(TABLE_DEPTH))
                begin
                    we    = 1'b1;
                    waddr = AW'(count_reg);
                    wx    = req_data.point_x;
                    wy    = req_data.point_y;
                end
                else if (req_take)
                begin
                    raddr = '0;
                end
            end
            S_SHIFT:
            begin
                raddr = idx_reg;
            end
            S_KEY:
            begin
                raddr = idx_reg - 1'b1;
            end
            S_SHWR:
            begin
                we    = 1'b1;
                waddr = pos_reg;
                if (place_now)
                begin
                    wx = key_x_reg;
                    wy = key_y_reg;
                end
                else
                begin
                    wx = xr_reg;
                    wy = yr_reg;
                end
                raddr = pos_reg - 2'd2;
            end
            S_RDLO:  raddr = AW'(count_reg - 1'b1);
            S_RDHI:  raddr = AW'(count_reg - 1'b1);
            S_PROBE: raddr = AW'(mid);
            S_RDA:   raddr = AW'(l_reg);
            S_RDB:   raddr = AW'(r_reg);
            default: raddr = pos_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_take)
                begin
                    if (req_data.req_type == REQ_INSERT)
                        state_next = (cnt_ext < (CW+1)'(TABLE_DEPTH) && sort_on_insert
                                      && count_reg != '0) ? S_SHIFT : S_IDLE;
                    else
                        state_next = (count_reg == '0) ? S_IDLE : S_RDLO;
                end
            S_SHIFT: state_next = S_KEY;
            S_KEY:   state_next = S_SHWR;
            S_SHWR:
                if (place_now)
                    state_next = sort_done ? S_IDLE : S_SHIFT;
            S_RDLO:  state_next = S_RDHI;
            S_RDHI:  state_next = S_CHK;
            S_CHK:
                state_next = ($signed(item_reg.point_x) < $signed(first_x_reg)
                           || $signed(item_reg.point_x) > $signed(xr_reg)) ? S_IDLE : S_PROBE;
            S_PROBE:
                state_next = (l_reg < r_reg - 1) ? S_CMP : S_RDA;
            S_CMP:
                state_next = ($signed(xr_reg) == $signed(item_reg.point_x)) ? S_IDLE : S_PROBE;
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:   state_next = (bit_reg == 7'd0) ? S_IDLE : S_DIV;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ordered_reg  <= 1'b1;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_full_reg && !res_stall)
                out_full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (req_take)
                    begin
                        if (req_data.req_type == REQ_INSERT)
                        begin
                            if (cnt_ext < (CW+1)'(TABLE_DEPTH))
                            begin
                                count_reg   <= count_reg + 1'b1;
                                ordered_reg <= sort_on_insert || (count_reg == '0);
                            end
                            if (!(cnt_ext < (CW+1)'(TABLE_DEPTH) && sort_on_insert
                                  && count_reg != '0))
                                out_full_reg <= 1'b1;
                        end
                        else if (count_reg == '0)
                            out_full_reg <= 1'b1;
                    end
                S_SHWR:
                    if (place_now && sort_done)
                        out_full_reg <= 1'b1;
                S_CHK:
                    if ($signed(item_reg.point_x) < $signed(first_x_reg)
                        || $signed(item_reg.point_x) > $signed(xr_reg))
                        out_full_reg <= 1'b1;
                S_CMP:
                    if ($signed(xr_reg) == $signed(item_reg.point_x))
                        out_full_reg <= 1'b1;
                S_DIV:
                    if (bit_reg == 7'd0)
                        out_full_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (req_take)
                begin
                    item_reg <= req_data;
                    pos_reg  <= AW'(count_reg);
                    // an ordered table only needs the new entry placed
                    idx_reg  <= ordered_reg ? AW'(count_reg) : AW'(1);
                    l_reg    <= '1;
                    r_reg    <= SW'(count_reg);
                    out_reg.value  <= '0;
                    if (req_data.req_type == REQ_INSERT)
                    begin
                        if (cnt_ext < (CW+1)'(TABLE_DEPTH))
                        begin
                            out_reg.status <= ST_OK;
                            out_reg.entry_count <= 7'(cnt_ext + 1'b1);
                        end
                        else
                        begin
                            out_reg.status <= ST_FULL;
                            out_reg.entry_count <= 7'(count_reg);
                        end
                    end
                    else
                    begin
                        out_reg.status <= (count_reg == '0) ? ST_EMPTY : ST_OK;
                        out_reg.entry_count <= 7'(count_reg);
                    end
                end
            S_KEY:
            begin
                key_x_reg <= xr_reg;
                key_y_reg <= yr_reg;
                pos_reg   <= idx_reg;
            end
            S_SHWR:
                if (place_now)
                    idx_reg <= idx_reg + 1'b1;
                else
                    pos_reg <= pos_reg - 1'b1;
            S_RDLO:
                first_x_reg <= xr_reg;
            S_CHK:
                if ($signed(item_reg.point_x) < $signed(first_x_reg)
                    || $signed(item_reg.point_x) > $signed(xr_reg))
                    out_reg.status <= ST_RANGE;
            S_PROBE:
                pos_reg <= AW'(mid);
            S_CMP:
                if ($signed(xr_reg) == $signed(item_reg.point_x))
                    out_reg.value <= yr_reg;
                else if ($signed(xr_reg) < $signed(item_reg.point_x))
                    l_reg <= SW'(pos_reg);
                else
                    r_reg <= SW'(pos_reg);
            S_RDB:
            begin
                ax_reg <= {xr_reg[31], xr_reg};
                ay_reg <= {yr_reg[31], yr_reg};
            end
            S_MUL:
            begin
                dy_reg <= {yr_reg[31], yr_reg} - ay_reg;
                dx_reg <= 33'({xr_reg[31], xr_reg} - ax_reg);
                dq_reg <= 33'({item_reg.point_x[31], item_reg.point_x} - ax_reg);
                bit_reg <= 7'd66;
                rem_reg <= '0;
            end
            S_DIV:
            begin
                if (bit_reg == 7'd66)
                begin
                    neg_reg <= dy_reg[32];
                    num_reg <= {2'b00, prod};
                    bit_reg <= 7'd65;
                end
                else
                begin
                    if (!trial[33])
                        rem_reg <= trial[32:0];
                    else
                        rem_reg <= {rem_reg[31:0], num_reg[65]};
                    num_reg <= {num_reg[64:0], !trial[33]};
                    if (bit_reg != 7'd0)
                        bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 7'd0)
                        out_reg.value <= 32'(ay_reg[31:0]
                            + (neg_reg ? -{num_reg[30:0], !trial[33]}
                                       : {num_reg[30:0], !trial[33]}));
                end
            end
            default: ;
        endcase
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> state_reg == S_IDLE) else $error("take outside idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= (CW+1)'(TABLE_DEPTH)) else $error("count overflow");
    a_res_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && res_stall) |=> out_full_reg) else $error("result lost");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
    import sbit_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam longint CYCLE_LIMIT = 3000000;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    sorted_breakpoint_interpolation_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Shadow of the breakpoint table, kept in step with every accepted request.
    logic signed [31:0] bp_x [DEPTH];
    logic signed [31:0] bp_y [DEPTH];
    int                 bp_count;
    logic               keep_sorted;

    out_item_t expected_q[$];
    int        fail_count;
    int        results_seen;
    int        lookups_seen;
    int        interp_seen;
    int        full_seen;
    longint    cycle_count;
    int        hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run: a hung handshake must not spin forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time, expected_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Work out the result of one request and update the shadow table.
    function automatic out_item_t predict_request(in_item_t req);
        out_item_t          res;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        int                 lo;
        int                 hi;
        int                 mid;
        int                 i;
        int                 j;
        logic               hit;
        longint             ax;
        longint             ay;
        longint             bx;
        longint             by;
        longint             dy;
        longint             q;
        logic [63:0]        mag;
        logic [63:0]        prod;
        logic [63:0]        dxu;
        res.value  = '0;
        res.status = ST_OK;
        if (req.req_type == REQ_INSERT)
        begin
            if (bp_count >= DEPTH)
            begin
                res.status = ST_FULL;
                full_seen++;
            end
            else
            begin
                bp_x[bp_count] = req.point_x;
                bp_y[bp_count] = req.point_y;
                bp_count++;
                if (keep_sorted)
                begin
                    // Stable insertion sort of the whole table; equal x keep their order.
                    for (i = 1; i < bp_count; i++)
                    begin
                        tx = bp_x[i];
                        ty = bp_y[i];
                        j = i;
                        while (j > 0 && bp_x[j-1] > tx)
                        begin
                            bp_x[j] = bp_x[j-1];
                            bp_y[j] = bp_y[j-1];
                            j--;
                        end
                        bp_x[j] = tx;
                        bp_y[j] = ty;
                    end
                end
            end
        end
        else
        begin
            tx = req.point_x;
            lookups_seen++;
            if (bp_count == 0)
                res.status = ST_EMPTY;
            else if (tx < bp_x[0] || tx > bp_x[bp_count-1])
                res.status = ST_RANGE;
            else
            begin
                lo  = -1;
                hi  = bp_count;
                hit = 1'b0;
                while (lo < hi - 1 && !hit)
                begin
                    mid = (lo + hi) / 2;
                    if (bp_x[mid] == tx)
                    begin
                        res.value = bp_y[mid];
                        hit = 1'b1;
                    end
                    else if (bp_x[mid] < tx)
                        lo = mid;
                    else
                        hi = mid;
                end
                if (!hit)
                begin
                    interp_seen++;
                    if (lo < 0) lo = 0;
                    if (hi > bp_count - 1) hi = bp_count - 1;
                    ax = bp_x[lo];
                    ay = bp_y[lo];
                    bx = bp_x[hi];
                    by = bp_y[hi];
                    dy = by - ay;
                    dxu = (bx > ax) ? 64'(bx - ax) : 64'd1;
                    mag = (dy < 0) ? 64'(-dy) : 64'(dy);
                    // Both factors stay below 2^32, so the product fits in 64 bits.
                    prod = mag * ((tx > ax) ? 64'(tx - ax) : 64'd0);
                    q = longint'(prod / dxu);
                    if (dy < 0) q = -q;
                    res.value = 32'(ay + q);
                end
            end
        end
        res.entry_count = 7'(bp_count);
        return res;
    endfunction

    // Result side: random stalls, plus a long hold-off when requested.
    initial
    begin
        int wait_n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else
            begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (wait_n > 0 && $urandom_range(0, 1) == 0)
                begin
                    out_stall = 1'b1;
                    repeat (wait_n - 1) @(negedge clk);
                end
                else
                    out_stall = 1'b0;
            end
        end
    end

    // Check each result against the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual value=%h status=%0d count=%0d",
                         $time, out_data.value, out_data.status, out_data.entry_count);
                fail_count++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (out_data.value !== exp_res.value)
                begin
                    $display("%0t value: expected %h, actual %h",
                             $time, exp_res.value, out_data.value);
                    fail_count++;
                end
                if (out_data.status !== exp_res.status)
                begin
                    $display("%0t status: expected %0d, actual %0d",
                             $time, exp_res.status, out_data.status);
                    fail_count++;
                end
                if (out_data.entry_count !== exp_res.entry_count)
                begin
                    $display("%0t entry_count: expected %0d, actual %0d",
                             $time, exp_res.entry_count, out_data.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Offer one request after an optional gap; predict it once it is taken.
    task automatic send_request(logic kind, logic [31:0] px, logic [31:0] py, bit gaps = 1);
        int gap;
        gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
        repeat (gap) @(negedge clk);
        in_data.req_type = kind;
        in_data.point_x  = px;
        in_data.point_y  = py;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.insert(expected_q.size(), predict_request(in_data));
        @(negedge clk);
        in_valid = 1'b0;
        in_data  = {1'($urandom), $urandom, $urandom};
    endtask

    // Drain every outstanding result, then let the back end settle.
    task automatic wait_idle();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // Only written while idle.
    task automatic set_sort_mode(logic mode);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = mode;
        @(negedge clk);
        cfg_we    = 1'b0;
        keep_sorted = mode;
    endtask

    // The table is cleared by reset only, so each phase fills onward from
    // where the previous one left off.
    task automatic test_directed();
        send_request(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, 32'h8000_0000, 32'h0);
        send_request(REQ_INSERT, 32'h0001_0000, 32'h0002_0000);
        send_request(REQ_LOOKUP, 32'h0001_0000, 32'h0);
        send_request(REQ_LOOKUP, 32'h0000_FFFF, 32'h0);
        send_request(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h0001_0000, 32'hFFFF_0000);
        send_request(REQ_LOOKUP, 32'h0001_0000, 32'h0);
        send_request(REQ_LOOKUP, 32'h8000_0001, 32'h0);
        send_request(REQ_LOOKUP, 32'h7FFF_FFFE, 32'h0);
        send_request(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        send_request(REQ_LOOKUP, 32'h8000_0000, 32'h0);
        send_request(REQ_LOOKUP, 32'hC000_0000, 32'h0);
        send_request(REQ_LOOKUP, 32'h4000_0000, 32'h0);
    endtask

    // Append out of order with repeated x, then turn ordering back on so the
    // next insert has to sort the whole table.
    task automatic test_resort();
        set_sort_mode(1'b0);
        repeat (12)
            send_request(REQ_INSERT, 32'($signed($urandom_range(0, 20)) - 10), $urandom);
        set_sort_mode(1'b1);
        send_request(REQ_INSERT, 32'($signed($urandom_range(0, 20)) - 10), $urandom);
        repeat (20)
            send_request(REQ_LOOKUP, 32'($signed($urandom_range(0, 24)) - 12), $urandom);
    endtask

    // Fill to capacity, hit the full case, and look up across the whole table.
    task automatic test_fill_and_lookup(int n_lookups, bit narrow);
        logic [31:0] px;
        while (bp_count < DEPTH)
        begin
            px = narrow ? 32'($signed($urandom_range(0, 4000)) - 2000) : $urandom;
            send_request(REQ_INSERT, px, $urandom);
        end
        send_request(REQ_INSERT, $urandom, $urandom);
        send_request(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        repeat (n_lookups)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(REQ_INSERT, $urandom, $urandom);
            else if ($urandom_range(0, 4) == 0)
                send_request(REQ_LOOKUP, bp_x[$urandom_range(0, DEPTH - 1)], $urandom);
            else if (narrow)
                send_request(REQ_LOOKUP, 32'($signed($urandom_range(0, 4400)) - 2200),
                             $urandom);
            else
                send_request(REQ_LOOKUP, $urandom, $urandom);
        end
    endtask

    // Receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_cycles = 600;
        repeat (12)
            send_request(REQ_LOOKUP, $urandom, $urandom, 0);
        wait_idle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b1;
        in_valid    = 1'b0;
        in_data     = '0;
        keep_sorted = 1'b1;
        bp_count    = 0;
        fail_count  = 0;
        results_seen = 0;
        lookups_seen = 0;
        interp_seen = 0;
        full_seen   = 0;
        cycle_count = 0;
        hold_cycles = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_resort();
        test_fill_and_lookup(470, 0);
        test_backpressure();
        // Table stays full from here on; toggle order mode and keep probing.
        set_sort_mode(1'b0);
        test_fill_and_lookup(300, 0);
        set_sort_mode(1'b1);
        test_fill_and_lookup(300, 1);
        set_sort_mode(1'b0);
        test_fill_and_lookup(300, 1);
        set_sort_mode(1'b1);
        test_fill_and_lookup(280, 0);
        wait_idle();

        $display("Covered %0d results: %0d lookups, %0d interpolated, %0d dropped inserts",
                 results_seen, lookups_seen, interp_seen, full_seen);
        $display("Both insert orders exercised, a full re-sort, and result-side backpressure");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
